// ----- src/episode_statistics_reduction_assert.svh -----
// Assertion macros shared by the episode statistics reduction RTL.
`ifndef EPISODE_STATISTICS_REDUCTION_ASSERT_SVH
`define EPISODE_STATISTICS_REDUCTION_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define ESR_ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("esr: invariant violated");

// A consequence that must hold in the same cycle as its trigger.
`define ESR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esr: same-cycle implication violated");

// A consequence that must hold in the cycle after its trigger.
`define ESR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esr: next-cycle implication violated");

`endif

// ----- src/esr_pkg.sv -----
// Shared constants and types of the episode statistics reduction block.
package esr_pkg;

    localparam int MAX_STEPS = 65536;
    localparam int FRAC_BITS = 16;

    localparam int DATA_W = 32;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int DIV_W = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [DATA_W-1:0] WEIGHT_HIGH_RESET = 32'd131072;
    localparam logic [DATA_W-1:0] WEIGHT_LOW_RESET = 32'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_HIGH = 1'b0,
        REG_WEIGHT_LOW  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- src/episode_statistics_reduction.sv -----
// Top level of the episode statistics reduction block.
//
// Input channel (in_valid/in_ready) carries one episode step per transfer.
// Output channel (out_valid/out_ready) carries one statistics record per
// episode, produced after the step marked last_step.
// Configuration: cfg_we writes cfg_data into the weight window register
// selected by cfg_index in the same cycle; write only while the block is idle.
// Each step passes through the transfer, a state of running sums and extremes,
// and a state for each of the two squares, which share a single registered
// 32x32 squarer. A new step is taken only after the previous one has left them.
// After the last step, three divisions by the step count run one after the
// other on a bit-serial divider, and out_valid rises once all three are done.
// The record sits in an output register: if the receiver stalls, it holds
// and steps of the next episode are still taken; a second record waits in
// the sequencer until the first has been transferred.
// Reset restores the window registers to their defaults and clears all
// running statistics; no clearing pass is needed.
`include "episode_statistics_reduction_assert.svh"

module episode_statistics_reduction (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [esr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [esr_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [esr_pkg::DATA_W-1:0]   value_error,
    input  logic [esr_pkg::DATA_W-1:0]          importance_weight,
    input  logic signed [esr_pkg::DATA_W-1:0]   advantage,
    input  logic signed [esr_pkg::DATA_W-1:0]   state_val,
    input  logic signed [esr_pkg::DATA_W-1:0]   kl_divergence,
    input  logic signed [esr_pkg::DATA_W-1:0]   reward,
    input  logic                                last_step,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [16:0]                         far_policy_fraction,
    output logic [62:0]                         mean_sq_error,
    output logic [31:0]                         max_abs_error,
    output logic [63:0]                         sum_sq_q,
    output logic signed [47:0]                  sum_q,
    output logic signed [32:0]                  max_q,
    output logic signed [32:0]                  min_q,
    output logic signed [47:0]                  total_reward,
    output logic signed [31:0]                  mean_kl
);
    import esr_pkg::*;

    localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;
    localparam logic signed [32:0] Q33_MAX = 33'sh0_FFFF_FFFF;
    localparam logic signed [32:0] Q33_MIN = 33'sh1_0000_0000;
    localparam logic [DIV_W-1:0] KL_POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [DIV_W-1:0] KL_NEG_LIMIT = 64'h0000_0000_8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_SQE,
        S_SQQ,
        S_DSTART,
        S_DWAIT,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SEL_FRAC,
        SEL_MSQ,
        SEL_KL
    } div_sel_t;

    function automatic logic [63:0] uadd_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic signed [47:0] sadd48(input logic signed [47:0] a,
                                                  input logic signed [32:0] b);
        logic signed [48:0] s;
        s = {a[47], a} + {{16{b[32]}}, b};
        if (s[48] != s[47])
        begin
            return s[48] ? S48_MIN : S48_MAX;
        end
        return s[47:0];
    endfunction

    state_t         state_reg;
    state_t         state_next;
    div_sel_t       sel_reg;

    logic [DATA_W-1:0]          weight_high_reg;
    logic [DATA_W-1:0]          weight_low_reg;

    // Latched step.
    logic [DATA_W-1:0]          ae_reg;
    logic [DATA_W-1:0]          w_reg;
    logic signed [32:0]         q_reg;
    logic signed [DATA_W-1:0]   kl_reg;
    logic signed [DATA_W-1:0]   rw_reg;
    logic                       last_reg;
    logic [32:0]                aq_reg;

    // Running statistics.
    logic [CNT_W-1:0]           step_count_reg;
    logic [CNT_W-1:0]           far_count_reg;
    logic [63:0]                sq_err_sum_reg;
    logic [DATA_W-1:0]          abs_max_reg;
    logic signed [32:0]         q_max_reg;
    logic signed [32:0]         q_min_reg;
    logic [63:0]                q_sq_sum_reg;
    logic signed [47:0]         q_sum_reg;
    logic signed [47:0]         reward_sum_reg;
    logic signed [47:0]         kl_sum_reg;

    // Division results.
    logic [16:0]                frac_res_reg;
    logic [62:0]                msq_res_reg;
    logic signed [31:0]         kl_res_reg;

    logic                       out_valid_reg;
    logic [16:0]                frac_out_reg;
    logic [62:0]                msq_out_reg;
    logic [31:0]                abs_out_reg;
    logic [63:0]                qsq_out_reg;
    logic signed [47:0]         qsum_out_reg;
    logic signed [32:0]         qmax_out_reg;
    logic signed [32:0]         qmin_out_reg;
    logic signed [47:0]         reward_out_reg;
    logic signed [31:0]         kl_out_reg;

    logic                       accept;
    logic [DATA_W-1:0]          ae_in;
    logic signed [32:0]         q_in;
    logic [32:0]                aq_next;
    logic                       far_hit;
    logic [DATA_W-1:0]          sq_op;
    logic [2*DATA_W-1:0]        sq_prod;
    logic [63:0]                sq_err_sum_next;
    logic [63:0]                q_sq_sum_next;
    logic signed [47:0]         q_sum_next;
    logic signed [47:0]         reward_sum_next;
    logic signed [47:0]         kl_sum_next;
    logic [47:0]                kl_mag;
    logic                       div_start;
    logic [DIV_W-1:0]           div_dividend;
    logic [DIV_W-1:0]           div_quotient;
    div_status_t                div_status;
    logic                       emit_go;
    logic                       have_steps;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        ae_in = value_error[DATA_W-1] ? (~value_error + 32'd1) : value_error;
        q_in = {advantage[DATA_W-1], advantage} + {state_val[DATA_W-1], state_val};
        aq_next = q_reg[32] ? (~q_reg + 33'd1) : q_reg;
        far_hit = (w_reg > weight_high_reg) || (w_reg < weight_low_reg);
        sq_op = (state_reg == S_SQE) ? aq_reg[DATA_W-1:0] : ae_reg;
        sq_err_sum_next = uadd_sat(sq_err_sum_reg, sq_prod);
        // A Q of -2^32 squares to 2^64, which pins the sum at its ceiling.
        q_sq_sum_next = aq_reg[32] ? '1 : uadd_sat(q_sq_sum_reg, sq_prod);
        q_sum_next = sadd48(q_sum_reg, q_reg);
        reward_sum_next = sadd48(reward_sum_reg, {rw_reg[DATA_W-1], rw_reg});
        kl_sum_next = sadd48(kl_sum_reg, {kl_reg[DATA_W-1], kl_reg});
        kl_mag = kl_sum_reg[47] ? (~kl_sum_reg + 48'd1) : kl_sum_reg;
        div_start = (state_reg == S_DSTART);
        case (sel_reg)
            SEL_FRAC: div_dividend = DIV_W'(far_count_reg) << FRAC_BITS;
            SEL_MSQ:  div_dividend = sq_err_sum_reg;
            default:  div_dividend = DIV_W'(kl_mag);
        endcase
        emit_go = !out_valid_reg || out_ready;
        have_steps = (step_count_reg != '0);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   state_next = accept ? S_ACC : S_IDLE;
            S_ACC:    state_next = S_SQE;
            S_SQE:    state_next = S_SQQ;
            S_SQQ:    state_next = last_reg ? S_DSTART : S_IDLE;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (div_status.done)
                begin
                    state_next = (sel_reg == SEL_KL) ? S_EMIT : S_DSTART;
                end
            end
            S_EMIT:   state_next = emit_go ? S_IDLE : S_EMIT;
        endcase
    end

    esr_sq u_sq (
        .clk    (clk),
        .op     (sq_op),
        .square (sq_prod)
    );

    esr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (step_count_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg <= SEL_FRAC;
            weight_high_reg <= WEIGHT_HIGH_RESET;
            weight_low_reg <= WEIGHT_LOW_RESET;
            ae_reg <= '0;
            w_reg <= '0;
            q_reg <= '0;
            kl_reg <= '0;
            rw_reg <= '0;
            last_reg <= 1'b0;
            aq_reg <= '0;
            step_count_reg <= '0;
            far_count_reg <= '0;
            sq_err_sum_reg <= '0;
            abs_max_reg <= '0;
            q_max_reg <= Q33_MIN;
            q_min_reg <= Q33_MAX;
            q_sq_sum_reg <= '0;
            q_sum_reg <= '0;
            reward_sum_reg <= '0;
            kl_sum_reg <= '0;
            frac_res_reg <= '0;
            msq_res_reg <= '0;
            kl_res_reg <= '0;
            out_valid_reg <= 1'b0;
            frac_out_reg <= '0;
            msq_out_reg <= '0;
            abs_out_reg <= '0;
            qsq_out_reg <= '0;
            qsum_out_reg <= '0;
            qmax_out_reg <= '0;
            qmin_out_reg <= '0;
            reward_out_reg <= '0;
            kl_out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WEIGHT_HIGH: weight_high_reg <= cfg_data;
                    REG_WEIGHT_LOW:  weight_low_reg <= cfg_data;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ae_reg <= ae_in;
                        w_reg <= importance_weight;
                        q_reg <= q_in;
                        kl_reg <= kl_divergence;
                        rw_reg <= reward;
                        last_reg <= last_step;
                    end
                end
                S_ACC:
                begin
                    if (step_count_reg < CNT_W'(MAX_STEPS))
                    begin
                        step_count_reg <= step_count_reg + 1'b1;
                        if (far_hit)
                        begin
                            far_count_reg <= far_count_reg + 1'b1;
                        end
                    end
                    if (ae_reg > abs_max_reg)
                    begin
                        abs_max_reg <= ae_reg;
                    end
                    if (q_reg > q_max_reg)
                    begin
                        q_max_reg <= q_reg;
                    end
                    if (q_reg < q_min_reg)
                    begin
                        q_min_reg <= q_reg;
                    end
                    q_sum_reg <= q_sum_next;
                    reward_sum_reg <= reward_sum_next;
                    kl_sum_reg <= kl_sum_next;
                    aq_reg <= aq_next;
                end
                S_SQE:
                begin
                    sq_err_sum_reg <= sq_err_sum_next;
                end
                S_SQQ:
                begin
                    q_sq_sum_reg <= q_sq_sum_next;
                    sel_reg <= SEL_FRAC;
                end
                S_DSTART:
                begin
                end
                S_DWAIT:
                begin
                    if (div_status.done)
                    begin
                        case (sel_reg)
                            SEL_FRAC:
                            begin
                                frac_res_reg <= div_quotient[16:0];
                                sel_reg <= SEL_MSQ;
                            end
                            SEL_MSQ:
                            begin
                                msq_res_reg <= div_quotient[63] ? '1 : div_quotient[62:0];
                                sel_reg <= SEL_KL;
                            end
                            default:
                            begin
                                // Truncation toward zero: divide the magnitude, then restore the sign.
                                if (kl_sum_reg[47])
                                begin
                                    kl_res_reg <= (div_quotient > KL_NEG_LIMIT)
                                        ? 32'sh8000_0000 : (~div_quotient[31:0] + 32'd1);
                                end
                                else
                                begin
                                    kl_res_reg <= (div_quotient > KL_POS_LIMIT)
                                        ? 32'sh7FFF_FFFF : div_quotient[31:0];
                                end
                            end
                        endcase
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        frac_out_reg <= have_steps ? frac_res_reg : '0;
                        msq_out_reg <= have_steps ? msq_res_reg : '0;
                        kl_out_reg <= have_steps ? kl_res_reg : '0;
                        abs_out_reg <= abs_max_reg;
                        qsq_out_reg <= q_sq_sum_reg;
                        qsum_out_reg <= q_sum_reg;
                        qmax_out_reg <= q_max_reg;
                        qmin_out_reg <= q_min_reg;
                        reward_out_reg <= reward_sum_reg;
                        step_count_reg <= '0;
                        far_count_reg <= '0;
                        sq_err_sum_reg <= '0;
                        abs_max_reg <= '0;
                        q_max_reg <= Q33_MIN;
                        q_min_reg <= Q33_MAX;
                        q_sq_sum_reg <= '0;
                        q_sum_reg <= '0;
                        reward_sum_reg <= '0;
                        kl_sum_reg <= '0;
                    end
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign far_policy_fraction = frac_out_reg;
    assign mean_sq_error = msq_out_reg;
    assign max_abs_error = abs_out_reg;
    assign sum_sq_q = qsq_out_reg;
    assign sum_q = qsum_out_reg;
    assign max_q = qmax_out_reg;
    assign min_q = qmin_out_reg;
    assign total_reward = reward_out_reg;
    assign mean_kl = kl_out_reg;

    `ESR_ASSERT_HOLDS(a_far_within_steps, clk, rst_n, far_count_reg <= step_count_reg)
    `ESR_ASSERT_HOLDS(a_step_bound, clk, rst_n, step_count_reg <= CNT_W'(MAX_STEPS))
    `ESR_ASSERT_IMP(a_q_order, clk, rst_n, step_count_reg != '0, q_min_reg <= q_max_reg)
    `ESR_ASSERT_IMP(a_div_start_idle, clk, rst_n, div_start, !div_status.busy)
    `ESR_ASSERT_NEXT(a_emit_loads, clk, rst_n, state_reg == S_EMIT && !out_valid_reg, out_valid_reg)

endmodule

// ----- src/esr_sq.sv -----
// Shared squaring unit with a registered product.
module esr_sq (
    input  logic                            clk,
    input  logic [esr_pkg::DATA_W-1:0]      op,
    output logic [2*esr_pkg::DATA_W-1:0]    square
);
    import esr_pkg::*;

    logic [2*DATA_W-1:0] square_reg;

    always_ff @(posedge clk)
    begin
        square_reg <= {{DATA_W{1'b0}}, op} * {{DATA_W{1'b0}}, op};
    end

    assign square = square_reg;

endmodule

// ----- src/esr_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module esr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [esr_pkg::DIV_W-1:0]   dividend,
    input  logic [esr_pkg::CNT_W-1:0]   divisor,
    output logic [esr_pkg::DIV_W-1:0]   quotient,
    output esr_pkg::div_status_t        status
);
    import esr_pkg::*;

    localparam int ITER_W = $clog2(DIV_W);

    logic [DIV_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   dvs_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [CNT_W:0]     rem_shift;
    logic [CNT_W:0]     rem_sub;
    logic               fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        fits = rem_shift >= {1'b0, dvs_reg};
        rem_sub = rem_shift - {1'b0, dvs_reg};
    end

    // The dividend shifts out at the top of quo_reg while quotient bits enter at the bottom.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
            dvs_reg <= '0;
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg <= dividend;
                rem_reg <= '0;
                dvs_reg <= divisor;
                iter_reg <= ITER_W'(DIV_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                rem_reg <= fits ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                if (iter_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg - 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign status = '{busy: busy_reg, done: done_reg};

endmodule

// ----- verif/episode_statistics_reduction_test.sv -----
// Self-checking testbench for the episode statistics reduction block.
`timescale 1ns / 100ps

module episode_statistics_reduction_test;

    import esr_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_CYCLES = 2500;
    localparam int LONG_EPISODE = 40;
    localparam longint S48_MAX = (64'sd1 <<< 47) - 1;
    localparam longint S48_MIN = -(64'sd1 <<< 47);
    localparam longint Q33_MAX = (64'sd1 <<< 32) - 1;
    localparam longint Q33_MIN = -(64'sd1 <<< 32);

    typedef struct {
        logic signed [31:0] verr;
        logic [31:0]        weight;
        logic signed [31:0] adv;
        logic signed [31:0] sval;
        logic signed [31:0] kl;
        logic signed [31:0] rew;
        logic               is_last;
    } step_t;

    typedef struct packed {
        logic [16:0] far_frac;
        logic [62:0] mean_sq;
        logic [31:0] err_peak;
        logic [63:0] q_sq_total;
        logic [47:0] q_total;
        logic [32:0] q_top;
        logic [32:0] q_bottom;
        logic [47:0] reward_total;
        logic [31:0] kl_mean;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] value_error = '0;
    logic [31:0] importance_weight = '0;
    logic signed [31:0] advantage = '0;
    logic signed [31:0] state_val = '0;
    logic signed [31:0] kl_divergence = '0;
    logic signed [31:0] reward = '0;
    logic last_step = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [16:0] far_policy_fraction;
    logic [62:0] mean_sq_error;
    logic [31:0] max_abs_error;
    logic [63:0] sum_sq_q;
    logic signed [47:0] sum_q;
    logic signed [32:0] max_q;
    logic signed [32:0] min_q;
    logic signed [47:0] total_reward;
    logic signed [31:0] mean_kl;

    episode_statistics_reduction uut (.*);

    always #6 clk = ~clk;

    // Predictor copy of the weight window and the running episode state.
    logic [31:0] win_high = WEIGHT_HIGH_RESET;
    logic [31:0] win_low = WEIGHT_LOW_RESET;
    int          steps_seen;
    int          far_steps;
    logic [63:0] err_sq_acc;
    logic [63:0] err_abs_peak;
    longint      q_peak;
    longint      q_floor;
    logic [63:0] q_sq_acc;
    longint      q_acc;
    longint      reward_acc;
    longint      kl_acc;

    step_t  step_backlog[$];
    stats_t pending_stats[$];
    int     queued_cnt = 0;
    int     accepted_cnt = 0;
    int     episodes_queued = 0;
    int     records_seen = 0;
    int     window_settings = 1;
    int     mismatches = 0;
    int     idle_run = 0;
    logic   in_taken = 1'b0;
    logic   quiet = 1'b0;
    logic   stall_req = 1'b0;
    logic   stall_done = 1'b0;
    int     hold_left = 0;

    function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic longint add_sat48(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > S48_MAX) return S48_MAX;
        if (s < S48_MIN) return S48_MIN;
        return s;
    endfunction

    task automatic clear_episode();
        steps_seen = 0;
        far_steps = 0;
        err_sq_acc = '0;
        err_abs_peak = '0;
        q_peak = Q33_MIN;
        q_floor = Q33_MAX;
        q_sq_acc = '0;
        q_acc = 0;
        reward_acc = 0;
        kl_acc = 0;
    endtask

    // Folds one step into the running state; the marked step closes the episode.
    task automatic absorb_step(input step_t s);
        longint ve, q, kl_avg;
        logic [63:0] ae, aq, n, msq;
        stats_t r;
        ve = longint'(s.verr);
        q = longint'(s.adv) + longint'(s.sval);
        if (steps_seen < MAX_STEPS)
        begin
            steps_seen++;
            if (s.weight > win_high || s.weight < win_low)
                far_steps++;
        end
        ae = (ve < 0) ? 64'(-ve) : 64'(ve);
        err_sq_acc = add_sat64(err_sq_acc, ae * ae);
        if (ae > err_abs_peak)
            err_abs_peak = ae;
        if (q > q_peak)
            q_peak = q;
        if (q < q_floor)
            q_floor = q;
        aq = (q < 0) ? 64'(-q) : 64'(q);
        // Only Q = -2^32 has a square that does not fit in 64 bits.
        q_sq_acc = (aq > 64'hFFFF_FFFF) ? '1 : add_sat64(q_sq_acc, aq * aq);
        q_acc = add_sat48(q_acc, q);
        reward_acc = add_sat48(reward_acc, longint'(s.rew));
        kl_acc = add_sat48(kl_acc, longint'(s.kl));
        if (s.is_last)
        begin
            r = '0;
            if (steps_seen != 0)
            begin
                n = 64'(steps_seen);
                r.far_frac = 17'((64'(far_steps) << FRAC_BITS) / n);
                msq = err_sq_acc / n;
                r.mean_sq = msq[63] ? {63{1'b1}} : msq[62:0];
                kl_avg = kl_acc / longint'(steps_seen);
                if (kl_avg > 64'sd2147483647)
                    kl_avg = 64'sd2147483647;
                if (kl_avg < -64'sd2147483648)
                    kl_avg = -64'sd2147483648;
                r.kl_mean = 32'(kl_avg);
            end
            r.err_peak = err_abs_peak[31:0];
            r.q_sq_total = q_sq_acc;
            r.q_total = 48'(q_acc);
            r.q_top = 33'(q_peak);
            r.q_bottom = 33'(q_floor);
            r.reward_total = 48'(reward_acc);
            pending_stats.insert(pending_stats.size(), r);
            clear_episode();
        end
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch in record %0d, %s: expected %h, got %h",
                     records_seen, field, exp_v, got_v);
    endtask

    task automatic check_record(input stats_t got);
        stats_t want;
        if (pending_stats.size() == 0)
        begin
            note_mismatch("unexpected record", '0, '0);
            return;
        end
        want = pending_stats.pop_front();
        if (got.far_frac !== want.far_frac)
            note_mismatch("far_policy_fraction", want.far_frac, got.far_frac);
        if (got.mean_sq !== want.mean_sq)
            note_mismatch("mean_sq_error", want.mean_sq, got.mean_sq);
        if (got.err_peak !== want.err_peak)
            note_mismatch("max_abs_error", want.err_peak, got.err_peak);
        if (got.q_sq_total !== want.q_sq_total)
            note_mismatch("sum_sq_q", want.q_sq_total, got.q_sq_total);
        if (got.q_total !== want.q_total)
            note_mismatch("sum_q", want.q_total, got.q_total);
        if (got.q_top !== want.q_top)
            note_mismatch("max_q", want.q_top, got.q_top);
        if (got.q_bottom !== want.q_bottom)
            note_mismatch("min_q", want.q_bottom, got.q_bottom);
        if (got.reward_total !== want.reward_total)
            note_mismatch("total_reward", want.reward_total, got.reward_total);
        if (got.kl_mean !== want.kl_mean)
            note_mismatch("mean_kl", want.kl_mean, got.kl_mean);
    endtask

    // Step sender: a new step goes out only after the previous transfer.
    always @(negedge clk)
    begin : sender
        step_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (step_backlog.size() > 0 && (quiet || $urandom_range(99) >= 6))
            begin
                nxt = step_backlog.pop_front();
                value_error <= nxt.verr;
                importance_weight <= nxt.weight;
                advantage <= nxt.adv;
                state_val <= nxt.sval;
                kl_divergence <= nxt.kl;
                reward <= nxt.rew;
                last_step <= nxt.is_last;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Record receiver, with one long hold-off so the block backs up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_req && !stall_done)
            begin
                stall_done = 1'b1;
                hold_left = STALL_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(99) >= 6);
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        step_t s;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                s.verr = value_error;
                s.weight = importance_weight;
                s.adv = advantage;
                s.sval = state_val;
                s.kl = kl_divergence;
                s.rew = reward;
                s.is_last = last_step;
                accepted_cnt++;
                absorb_step(s);
            end
            if (out_valid && out_ready)
            begin
                check_record({far_policy_fraction, mean_sq_error, max_abs_error, sum_sq_q,
                              sum_q, max_q, min_q, total_reward, mean_kl});
                records_seen++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= IDLE_LIMIT)
            begin
                $display("Timeout: %0d cycles without a transfer", IDLE_LIMIT);
                $display("FAIL episode_statistics_reduction");
                $finish;
            end
        end
    end

    task automatic queue_step(input logic [31:0] ve, input logic [31:0] w,
                              input logic [31:0] adv, input logic [31:0] sv,
                              input logic [31:0] kl, input logic [31:0] rw, input logic fin);
        step_t s;
        s.verr = ve;
        s.weight = w;
        s.adv = adv;
        s.sval = sv;
        s.kl = kl;
        s.rew = rw;
        s.is_last = fin;
        step_backlog.insert(step_backlog.size(), s);
        queued_cnt++;
        if (fin)
            episodes_queued++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'($urandom_range(255)) - 32'd128;
            default: return $urandom;
        endcase
    endfunction

    // Weights cluster on the window edges so both comparisons get exercised.
    function automatic logic [31:0] pick_weight();
        logic [63:0] span;
        case ($urandom_range(9))
            0: return win_low;
            1: return win_low - 32'd1;
            2: return win_high;
            3: return win_high + 32'd1;
            4:
            begin
                if (win_low > win_high)
                    return $urandom;
                span = 64'(win_high) - 64'(win_low) + 64'd1;
                return win_low + 32'(64'($urandom) % span);
            end
            5: return 32'h0000_0000;
            6: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(input int n_items);
        int left, len;
        left = n_items;
        while (left > 0)
        begin
            len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(40, 7);
            if (len > left)
                len = left;
            for (int k = 1; k <= len; k++)
                queue_step(pick_word(), pick_weight(), pick_word(), pick_word(),
                           pick_word(), pick_word(), k == len);
            left -= len;
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_WEIGHT_HIGH)
            win_high = val;
        else
            win_low = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_window(input logic [31:0] hi, input logic [31:0] lo);
        write_reg(REG_WEIGHT_HIGH, hi);
        write_reg(REG_WEIGHT_LOW, lo);
        window_settings++;
        @(posedge clk);
    endtask

    // Waits until every step is in and every record is out, then lets the
    // divider run dry before anything else happens.
    task automatic settle();
        while (accepted_cnt != queued_cnt || pending_stats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] hi, lo;
        clear_episode();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-step episode on the lower window edge.
        queue_step(32'h0, 32'd32768, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        // Field extremes; the first step has Q = -2^32, whose square overflows.
        queue_step(32'h8000_0000, 32'h0, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 1'b0);
        queue_step(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        queue_step(32'hFFFF_FFFF, 32'd131072, 32'h1, 32'hFFFF_FFFF,
                   32'hFFFF_0000, 32'h0, 1'b0);
        queue_step(32'h0001_0000, 32'd32767, 32'h0002_0000, 32'hFFFF_8000,
                   32'h0000_8000, 32'hFFFF_FFFF, 1'b1);
        // Negative KL divergence throughout, one weight just above the window.
        queue_step(32'h0000_4000, 32'd131073, 32'h0, 32'h0001_0000,
                   32'hFFFE_0000, 32'h0001_0000, 1'b0);
        queue_step(32'hFFFF_C000, 32'd65536, 32'hFFFF_0000, 32'h0,
                   32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_step(32'h0, 32'd100000, 32'h5, 32'h5, 32'h8000_0000, 32'h1, 1'b1);
        // Every step outside the window gives a fraction of exactly one.
        queue_step(32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        queue_step(32'h8765_4321, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        // A longer episode with the most negative KL divergence and the
        // largest reward on every step.
        for (int k = 0; k < LONG_EPISODE; k++)
            queue_step(pick_word(), pick_weight(), pick_word(), pick_word(),
                       32'h8000_0000, 32'h7FFF_FFFF, k == LONG_EPISODE - 1);
        queue_random(100);
        settle();

        // Inverted window: every step is far.
        set_window(32'h0, 32'hFFFF_FFFF);
        queue_random(70);
        settle();

        // Widest window: no step is far.
        set_window(32'hFFFF_FFFF, 32'h0);
        queue_random(70);
        settle();

        hi = $urandom;
        lo = $urandom;
        if (lo > hi)
            {hi, lo} = {lo, hi};
        set_window(hi, lo);
        queue_random(70);
        settle();
        // Short episodes against a stalled receiver, so the block backs up.
        @(posedge clk);
        stall_req = 1'b1;
        for (int k = 0; k < 30; k++)
            queue_step(pick_word(), pick_weight(), pick_word(), pick_word(),
                       pick_word(), pick_word(), 1'b1);
        settle();

        set_window(WEIGHT_HIGH_RESET, WEIGHT_LOW_RESET);
        quiet = 1'b1;
        queue_random(60);
        settle();

        $display("Ran %0d steps in %0d episodes over %0d weight windows; %0d records checked.",
                 accepted_cnt, episodes_queued, window_settings, records_seen);
        $display("Covered field extremes, inverted and full windows, a long episode and a long receiver stall.");
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("PASS episode_statistics_reduction");
        else
            $display("FAIL episode_statistics_reduction");
        $finish;
    end

endmodule
